### design/plti_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the piecewise-linear table interpolation unit.
// No dependencies; compiled first.

package plti_pkg;

    // Default sizing, handed to the top level parameters
    localparam int PLTI_MAX_ENTRIES = 16;
    localparam int PLTI_FRAC_BITS   = 16;

    // Fixed field widths
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 4;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 3;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INTERP = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOW    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIGH   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WRITE  = 3'd4;

    // Register index (word address paddr[2])
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic                     op;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_breakpoint;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] query_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [STATUS_W-1:0]      status;
    } t_out_item;

endpackage

### design/plti_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the input and result channels.
// Depends on plti_pkg for the payload types.

interface plti_in_if import plti_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface plti_out_if import plti_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/piecewise_linear_table_interp_unit.sv
`timescale 1ns / 1ps
// Clamped piecewise-linear lookup over a breakpoint/value table, signed fixed point.
// Top level; depends on plti_pkg and the stream interfaces in plti_if.sv.
//
// One item is handled at a time, all arithmetic going through one shared
// adder/subtractor under a small sequencer, so latency follows the number of
// adder operations. A write item stores one entry and its result (status
// write done) is registered on the cycle after acceptance, as is the answer
// to a query on an empty table. A low clamp is decided in S_CHK_LO, a high
// clamp in S_CHK_HI. An interpolating query scans k entries (1 up to
// MAX_ENTRIES-1) for the bracket, forms b1-b0 and q-b0, divides, forms
// v1-v0 and its magnitude, multiplies and applies the step to v0. The
// breakpoint and value tables have one write port and a registered read
// port, one entry per cycle during the bracket scan; the quotient is found by
// restoring division one bit per cycle and the product by shift-and-add one
// bit per cycle. The input is ready only when the sequencer is idle and the
// result register is free or being emptied. entry_count lives at byte address
// 0 of the APB port; counts above MAX_ENTRIES act as MAX_ENTRIES. Table entries
// hold no reset value and must be written before a query reaches them.

module piecewise_linear_table_interp_unit import plti_pkg::*; #(
    parameter int MAX_ENTRIES = PLTI_MAX_ENTRIES,
    parameter int FRAC_BITS   = PLTI_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    plti_in_if.sink            i_in,
    plti_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW     = $clog2(MAX_ENTRIES);
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int QW     = FRAC_BITS + 1;
    localparam int SCW    = $clog2(FRAC_BITS + 1);
    // wide enough for the full ratio * |dv| magnitude plus a sign bit
    localparam int ALU_W  = FRAC_BITS + 35;
    localparam logic [QW-1:0] QUO_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHK_LO = 4'd1;
    localparam logic [3:0] S_CHK_HI = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_DEN    = 4'd4;
    localparam logic [3:0] S_DIFF   = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_DV     = 4'd7;
    localparam logic [3:0] S_ABS    = 4'd8;
    localparam logic [3:0] S_MUL    = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] r_count;
    logic               apb_wr;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? PDATA_W'(r_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (apb_wr && paddr[2] == REG_ENTRY_COUNT) begin
            r_count <= pwdata[COUNT_W-1:0];
        end
    end

    // effective count, clamped to the table depth
    logic [CW-1:0] count_eff;
    always_comb begin
        if (32'(r_count) > MAX_ENTRIES) begin
            count_eff = CW'(MAX_ENTRIES);
        end else begin
            count_eff = CW'(r_count);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    logic [3:0]               r_state, n_state;
    logic [AW-1:0]            r_addr, n_addr;
    logic [AW-1:0]            r_last, n_last;
    logic signed [DATA_W-1:0] r_q, n_q;
    logic signed [DATA_W-1:0] r_b0, n_b0;
    logic signed [DATA_W-1:0] r_v0, n_v0;
    logic signed [DATA_W-1:0] r_b1, n_b1;
    logic signed [DATA_W-1:0] r_v1, n_v1;
    logic [DATA_W-1:0]        r_den, n_den;
    logic [DATA_W-1:0]        r_rem, n_rem;
    logic [QW-1:0]            r_quo, n_quo;
    logic [SCW-1:0]           r_cnt, n_cnt;
    logic [DATA_W:0]          r_dv, n_dv;     // v1-v0, then its magnitude
    logic                     r_neg, n_neg;
    logic [ALU_W-1:0]         r_acc, n_acc;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out_data, n_out_data;

    logic in_acc;
    logic tbl_we;
    logic [AW-1:0] tbl_waddr;

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // writes past the table are dropped but still acknowledged
    assign tbl_we    = in_acc && (i_in.data.op == OP_WRITE)
                       && (32'(i_in.data.entry_index) < MAX_ENTRIES);
    assign tbl_waddr = AW'(i_in.data.entry_index);

    // ------------------------------------------------------------------
    // Table memories: one write, one registered read per cycle
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] r_bp_mem  [MAX_ENTRIES];
    logic signed [DATA_W-1:0] r_val_mem [MAX_ENTRIES];
    logic signed [DATA_W-1:0] r_bp_rd;
    logic signed [DATA_W-1:0] r_val_rd;

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_bp_mem[tbl_waddr]  <= i_in.data.entry_breakpoint;
            r_val_mem[tbl_waddr] <= i_in.data.entry_value;
        end
        r_bp_rd  <= r_bp_mem[n_addr];
        r_val_rd <= r_val_mem[n_addr];
    end

    // ------------------------------------------------------------------
    // Shared adder/subtractor
    // ------------------------------------------------------------------
    logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_sub;
    logic             alu_neg;
    logic [DATA_W:0]  div_t;

    assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_neg = alu_sum[ALU_W-1];
    // partial remainder: first step unshifted (integer bit of the ratio)
    assign div_t   = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_last      = r_last;
        n_q         = r_q;
        n_b0        = r_b0;
        n_v0        = r_v0;
        n_b1        = r_b1;
        n_v1        = r_v1;
        n_den       = r_den;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_dv        = r_dv;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b1;

        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.data.op == OP_WRITE) begin
                        n_out_valid             = 1'b1;
                        n_out_data.result_value = '0;
                        n_out_data.status       = ST_WRITE;
                    end else if (count_eff == '0) begin
                        n_out_valid             = 1'b1;
                        n_out_data.result_value = '0;
                        n_out_data.status       = ST_EMPTY;
                    end else begin
                        n_q     = i_in.data.query_value;
                        n_last  = AW'(count_eff - CW'(1));
                        n_addr  = '0;
                        n_state = S_CHK_LO;
                    end
                end
            end

            // q <= bp[0] ?
            S_CHK_LO: begin
                alu_a = ALU_W'(r_bp_rd);
                alu_b = ALU_W'(r_q);
                if (!alu_neg) begin
                    n_out_valid             = 1'b1;
                    n_out_data.result_value = r_val_rd;
                    n_out_data.status       = ST_LOW;
                    n_state                 = S_IDLE;
                end else begin
                    n_b0    = r_bp_rd;
                    n_v0    = r_val_rd;
                    n_addr  = r_last;
                    n_state = S_CHK_HI;
                end
            end

            // q >= bp[last] ?
            S_CHK_HI: begin
                alu_a = ALU_W'(r_q);
                alu_b = ALU_W'(r_bp_rd);
                if (!alu_neg) begin
                    n_out_valid             = 1'b1;
                    n_out_data.result_value = r_val_rd;
                    n_out_data.status       = ST_HIGH;
                    n_state                 = S_IDLE;
                end else begin
                    n_addr  = AW'(1);
                    n_state = S_SCAN;
                end
            end

            // first entry with bp >= q, stopping at the last one
            S_SCAN: begin
                alu_a = ALU_W'(r_bp_rd);
                alu_b = ALU_W'(r_q);
                if (!alu_neg || r_addr == r_last) begin
                    n_b1    = r_bp_rd;
                    n_v1    = r_val_rd;
                    n_state = S_DEN;
                end else begin
                    n_b0   = r_bp_rd;
                    n_v0   = r_val_rd;
                    n_addr = r_addr + AW'(1);
                end
            end

            S_DEN: begin
                alu_a   = ALU_W'(r_b1);
                alu_b   = ALU_W'(r_b0);
                n_den   = alu_sum[DATA_W-1:0];
                n_state = S_DIFF;
            end

            S_DIFF: begin
                alu_a   = ALU_W'(r_q);
                alu_b   = ALU_W'(r_b0);
                n_rem   = alu_sum[DATA_W-1:0];
                n_cnt   = '0;
                n_quo   = '0;
                n_state = S_DIV;
            end

            // restoring division, one quotient bit per cycle
            S_DIV: begin
                alu_a = ALU_W'(div_t);
                alu_b = ALU_W'(r_den);
                if (!alu_neg) begin
                    n_rem = alu_sum[DATA_W-1:0];
                end else begin
                    n_rem = div_t[DATA_W-1:0];
                end
                n_quo = {r_quo[QW-2:0], ~alu_neg};
                if (r_cnt == SCW'(FRAC_BITS)) begin
                    n_state = S_DV;
                end else begin
                    n_cnt = r_cnt + SCW'(1);
                end
            end

            S_DV: begin
                alu_a   = ALU_W'(r_v1);
                alu_b   = ALU_W'(r_v0);
                n_dv    = alu_sum[DATA_W:0];
                n_neg   = alu_neg;
                n_state = S_ABS;
            end

            S_ABS: begin
                if (r_neg) begin
                    alu_a = '0;
                    alu_b = ALU_W'(signed'(r_dv));
                end else begin
                    alu_a   = ALU_W'(signed'(r_dv));
                    alu_sub = 1'b0;
                end
                n_dv    = alu_sum[DATA_W:0];
                n_acc   = '0;
                n_cnt   = '0;
                n_state = S_MUL;
            end

            // shift-and-add, ratio MSB first
            S_MUL: begin
                alu_a   = {r_acc[ALU_W-2:0], 1'b0};
                alu_b   = r_quo[QW-1] ? ALU_W'(r_dv) : '0;
                alu_sub = 1'b0;
                n_acc   = alu_sum;
                n_quo   = {r_quo[QW-2:0], 1'b0};
                if (r_cnt == SCW'(FRAC_BITS)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + SCW'(1);
                end
            end

            // v0 +/- truncated step
            S_FIN: begin
                alu_a                   = ALU_W'(r_v0);
                alu_b                   = ALU_W'(r_acc >> FRAC_BITS);
                alu_sub                 = r_neg;
                n_out_valid             = 1'b1;
                n_out_data.result_value = alu_sum[DATA_W-1:0];
                n_out_data.status       = ST_INTERP;
                n_state                 = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_addr      <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_q        <= n_q;
        r_b0       <= n_b0;
        r_v0       <= n_v0;
        r_b1       <= n_b1;
        r_v1       <= n_v1;
        r_den      <= n_den;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_dv       <= n_dv;
        r_neg      <= n_neg;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] fin_res;
    logic                     fin_between;

    assign fin_res     = alu_sum[DATA_W-1:0];
    assign fin_between = ((fin_res >= r_v0) && (fin_res <= r_v1))
                         || ((fin_res <= r_v0) && (fin_res >= r_v1));

    // write item answers on the next cycle
    a_write_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.data.op == OP_WRITE) |=>
        (o_out.valid && o_out.data.status == ST_WRITE && o_out.data.result_value == '0))
        else $error("write item not acknowledged");

    // the bracket always has b0 < b1, so the divisor is nonzero
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIFF) |-> (r_den != '0))
        else $error("zero divisor");

    // ratio never exceeds one
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DV) |-> (r_quo <= QUO_ONE))
        else $error("ratio above one");

    // interpolated result stays between the bracketing values
    a_result_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> fin_between)
        else $error("interpolated result out of bracket");

endmodule

### tb/sv/plti_interp_checker.sv
`timescale 1ns / 1ps
// Result checker for the piecewise-linear table unit. It watches both item channels
// and the APB register writes, predicts each answer and compares the answers in order.
// Depends on plti_pkg and the stream interfaces in plti_if.sv.

module plti_interp_checker import plti_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    plti_in_if                 i_in_mon,
    plti_out_if                i_out_mon,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output int                 o_pending,
    output int                 o_errors,
    output int                 o_interp_count
);

    localparam int PRINT_CAP = 100;

    logic signed [DATA_W-1:0] bp_mem  [PLTI_MAX_ENTRIES];
    logic signed [DATA_W-1:0] val_mem [PLTI_MAX_ENTRIES];
    logic [COUNT_W-1:0]       entry_count;
    t_out_item                expected_answers [$];

    initial begin
        o_pending      = 0;
        o_errors       = 0;
        o_interp_count = 0;
        entry_count    = '0;
    end

    task automatic report_mismatch(input string msg);
        if (o_errors < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
        o_errors++;
    endtask

    // Expected answer for one item; write items also update the table copy.
    function automatic t_out_item predict_answer(input t_in_item it);
        t_out_item ans;
        int        n;
        int        i;
        longint    q, b0, b1, v0, v1, ratio, prod, step;
        ans.result_value = '0;
        if (it.op == OP_WRITE) begin
            if (it.entry_index < PLTI_MAX_ENTRIES) begin
                bp_mem[it.entry_index]  = it.entry_breakpoint;
                val_mem[it.entry_index] = it.entry_value;
            end
            ans.status = ST_WRITE;
        end else begin
            n = (entry_count > PLTI_MAX_ENTRIES) ? PLTI_MAX_ENTRIES : int'(entry_count);
            q = $signed(it.query_value);
            if (n == 0) begin
                ans.status = ST_EMPTY;
            end else if (q <= bp_mem[0]) begin
                ans.result_value = val_mem[0];
                ans.status       = ST_LOW;
            end else if (q >= bp_mem[n-1]) begin
                ans.result_value = val_mem[n-1];
                ans.status       = ST_HIGH;
            end else begin
                i = 1;
                while (i < n - 1 && bp_mem[i] < q)
                    i++;
                b0 = bp_mem[i-1];
                b1 = bp_mem[i];
                v0 = val_mem[i-1];
                v1 = val_mem[i];
                // b0 < q <= b1 holds even on an unsorted table
                ratio = ((q - b0) <<< PLTI_FRAC_BITS) / (b1 - b0);
                prod  = ratio * (v1 - v0);
                step  = ((prod < 0) ? -prod : prod) >>> PLTI_FRAC_BITS;
                ans.result_value = DATA_W'((prod < 0) ? v0 - step : v0 + step);
                ans.status       = ST_INTERP;
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            expected_answers.delete();
            entry_count = '0;
            for (int k = 0; k < PLTI_MAX_ENTRIES; k++) begin
                bp_mem[k]  = '0;
                val_mem[k] = '0;
            end
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr[PADDR_W-1:2] == REG_ENTRY_COUNT)
                entry_count = i_pwdata[COUNT_W-1:0];
            if (i_in_mon.valid && i_in_mon.ready) begin
                want = predict_answer(i_in_mon.data);
                if (want.status == ST_INTERP)
                    o_interp_count++;
                expected_answers = {expected_answers, want};
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = i_out_mon.data;
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with nothing expected: value %0h status %0d",
                        got.result_value, got.status));
                end else begin
                    want = expected_answers.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.result_value !== want.result_value)
                        report_mismatch($sformatf(
                            "result_value %0h, expected %0h (status %0d)",
                            got.result_value, want.result_value, want.status));
                end
            end
        end
        o_pending = expected_answers.size();
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for piecewise_linear_table_interp_unit: clock, reset, APB writes,
// item stimulus with idling on both sides, and the verdict.
// Depends on plti_pkg, plti_if.sv, the unit and plti_interp_checker.

module tb;
    import plti_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;  // quiet cycles; worst case is the hold-off plus one query
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
    localparam int ITEMS_PER_PHASE = 235;   // three idle mixes, about 700 random items
    localparam int SETTLE_CYCLES   = 80;    // above the longest interpolation latency

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    plti_in_if  in_ch ();
    plti_out_if out_ch ();

    int pending_results;
    int mismatch_count;
    int interp_count;

    // Idle percentages for the two sides, set per phase
    int send_gap_pct;
    int recv_gap_pct;

    // Hold-off handshake between the stimulus and the receiver process
    int hold_asked;
    int hold_served = 0;
    int hold_left   = 0;

    int quiet_cycles = 0;
    int n_items      = 0;
    int n_writes     = 0;
    int n_queries    = 0;
    int n_cfg_writes = 0;

    // Stimulus-side view of the table, used only to aim queries
    logic signed [DATA_W-1:0]    table_bp [PLTI_MAX_ENTRIES];
    logic [PLTI_MAX_ENTRIES-1:0] loaded;
    int                          active_entries;

    piecewise_linear_table_interp_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    plti_interp_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_mon       (in_ch),
        .i_out_mon      (out_ch),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_pending      (pending_results),
        .o_errors       (mismatch_count),
        .o_interp_count (interp_count)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering meanwhile.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            out_ch.ready <= 1'b0;
            hold_served  <= hold_asked;
            hold_left    <= HOLD_CYCLES;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Watchdog: too long without any item moving on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    // APB write of entry_count: setup cycle, then access until pready
    task automatic write_entry_count(input int unsigned count);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ENTRY_COUNT, 2'b00};
        pwdata  <= PDATA_W'(count);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        active_entries = (count > PLTI_MAX_ENTRIES) ? PLTI_MAX_ENTRIES : int'(count);
        n_cfg_writes++;
    endtask

    // Offer one item, with a random gap first; valid is left high on return so
    // back-to-back items keep it up. Exactly one valid update per time step.
    task automatic offer_item(input t_in_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct)
            gap++;
        in_ch.valid <= (gap == 0);
        in_ch.data  <= it;
        if (gap > 0) begin
            repeat (gap) @(posedge clk);
            in_ch.valid <= 1'b1;
        end
        do @(posedge clk); while (!in_ch.ready);
        n_items++;
        if (it.op == OP_WRITE) begin
            n_writes++;
            table_bp[it.entry_index] = it.entry_breakpoint;
            loaded[it.entry_index]   = 1'b1;
        end else begin
            n_queries++;
        end
    endtask

    // Sender pauses until every expected result has come back
    task automatic settle_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    function automatic t_in_item make_write(input int idx, input int bp, input int val);
        t_in_item it;
        it.op               = OP_WRITE;
        it.entry_index      = IDX_W'(idx);
        it.entry_breakpoint = bp;
        it.entry_value      = val;
        it.query_value      = $urandom;  // don't-care field, kept toggling
        return it;
    endfunction

    function automatic t_in_item make_query(input int q);
        t_in_item it;
        it.op               = OP_QUERY;
        it.entry_index      = IDX_W'($urandom_range(15));
        it.entry_breakpoint = $urandom;
        it.entry_value      = $urandom;
        it.query_value      = q;
        return it;
    endfunction

    // Query aimed at the loaded table: on and next to breakpoints, inside
    // brackets, outside both ends, and plain noise
    function automatic int pick_query();
        int     j;
        longint lo, hi;
        if (active_entries == 0)
            return $urandom;
        j = $urandom_range(active_entries - 1);
        case ($urandom_range(9))
            0: return table_bp[j];
            1: return table_bp[j] + 1;
            2: return table_bp[j] - 1;
            3, 4, 5, 6: begin
                if (j + 1 < active_entries) begin
                    lo = table_bp[j];
                    hi = table_bp[j+1];
                    if (hi > lo)
                        return 32'(lo + $urandom_range(0, 32'(hi - lo)));
                end
                return $urandom;
            end
            7: return $urandom;
            8: return 32'h8000_0000;
            default: return 32'h7fff_ffff;
        endcase
    endfunction

    // Load entries 0..n-1: spread over the full range, dense with repeats,
    // or unsorted
    task automatic load_table(input int n);
        int     mode;
        int     bp;
        int     val;
        longint slot;
        longint acc;
        mode = $urandom_range(99);
        slot = (longint'(1) << 32) / n;
        acc  = int'($urandom);
        for (int i = 0; i < n; i++) begin
            if (mode < 40) begin
                bp = 32'(-(longint'(1) << 31) + i * slot + $urandom_range(0, 32'(slot - 1)));
            end else if (mode < 85) begin
                if (i > 0)
                    acc = acc + $urandom_range(0, 3000);
                if (acc > 64'sd2147483647)
                    acc = 64'sd2147483647;
                bp = 32'(acc);
            end else begin
                bp = $urandom;
            end
            if ($urandom_range(1))
                val = $urandom;
            else
                val = $urandom_range(0, 200000) - 100000;
            offer_item(make_write(i, bp, val));
        end
    endtask

    initial begin
        int                          count;
        int                          phase_start;
        int                          seg_no;
        logic [PLTI_MAX_ENTRIES-1:0] need;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        send_gap_pct   = 18;
        recv_gap_pct   = 50;
        hold_asked     = 0;
        loaded         = '0;
        active_entries = 0;
        seg_no         = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // ---- Directed part ----
        // Empty table answers at both query extremes
        write_entry_count(0);
        offer_item(make_query(32'h8000_0000));
        offer_item(make_query(32'h7fff_ffff));
        // Field extremes; entries 2 and 3 share a breakpoint
        offer_item(make_write(0, 32'h8000_0000, 32'h7fff_ffff));
        offer_item(make_write(1, 32'h0000_0000, 32'h8000_0000));
        offer_item(make_write(2, 32'h7fff_ffff, 32'h7fff_ffff));
        offer_item(make_write(3, 32'h7fff_ffff, 32'h0000_0000));
        settle_results();

        // Single entry: at the breakpoint clamps low, just above clamps high
        write_entry_count(1);
        offer_item(make_query(32'h8000_0000));
        offer_item(make_query(32'h8000_0001));
        settle_results();

        // Three entries: widest brackets, full swing of values, exact breakpoint,
        // ratio of zero just above the lower breakpoint
        write_entry_count(3);
        offer_item(make_query(32'h8000_0000));
        offer_item(make_query(32'hffff_ffff));
        offer_item(make_query(32'h0000_0000));
        offer_item(make_query(32'h0000_0001));
        offer_item(make_query(32'h7fff_fffe));
        offer_item(make_query(32'h7fff_ffff));
        settle_results();

        // Four entries with a repeated last breakpoint
        write_entry_count(4);
        offer_item(make_query(32'h7fff_fffe));
        offer_item(make_query(32'h7fff_ffff));

        // ---- Random part: three idle mixes ----
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct = 18;
                    recv_gap_pct = 50;
                end
                1: begin
                    send_gap_pct = 50;
                    recv_gap_pct = 18;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            phase_start = n_items;
            while (n_items - phase_start < ITEMS_PER_PHASE) begin
                // Register writes only with the unit idle
                settle_results();
                if (seg_no == 0)
                    count = PLTI_MAX_ENTRIES;
                else if (seg_no == 1)
                    count = 31;  // beyond the table, acts as full
                else begin
                    case ($urandom_range(7))
                        0: count = 0;
                        1: count = 1;
                        2: count = 2;
                        3: count = PLTI_MAX_ENTRIES;
                        4: count = 31;
                        5: count = $urandom_range(3, PLTI_MAX_ENTRIES - 1);
                        6: count = $urandom_range(PLTI_MAX_ENTRIES + 1, 30);
                        default: count = $urandom_range(1, PLTI_MAX_ENTRIES);
                    endcase
                end
                seg_no++;
                write_entry_count(count);

                // Every entry a query may touch must hold a written value
                need = PLTI_MAX_ENTRIES'((longint'(1) << active_entries) - 1);
                if (active_entries > 0 && (((loaded & need) != need) || $urandom_range(1)))
                    load_table(active_entries);

                // One long receiver hold-off while the sender keeps going
                if (phase == 0 && hold_asked == 0 && n_items - phase_start > 60)
                    hold_asked++;

                repeat ($urandom_range(8, 30)) begin
                    if ($urandom_range(7) == 0)
                        offer_item(make_write($urandom_range(15), $urandom, $urandom));
                    else
                        offer_item(make_query(pick_query()));
                end
            end
        end

        settle_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d items (%0d table writes, %0d lookups, %0d interpolated) across %0d entry_count writes.",
                 n_items, n_writes, n_queries, interp_count, n_cfg_writes);
        $display("Idle mixes sender/receiver 18/50, 50/18, 0/0, with one %0d-cycle receiver hold-off.",
                 HOLD_CYCLES);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

### sim.f
design/plti_pkg.sv
design/plti_if.sv
design/piecewise_linear_table_interp_unit.sv
tb/sv/plti_interp_checker.sv
tb/sv/tb.sv
